/* src/dmf_pkg.sv */
// Shared types and constants of the dual mailbox FIFO core.
package dmf_pkg;

    localparam int DATA_W      = 32;
    localparam int STATUS_W    = 5;
    localparam int IRQ_W       = 2;
    localparam int CMD_W       = 2;
    localparam int S_TUSER_W   = 3;
    localparam int M_TDATA_W   = 48;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 1;

    typedef enum logic [CMD_W-1:0] {
        CMD_SEND  = 2'd0,
        CMD_RECV  = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    localparam logic [CFG_INDEX_W-1:0] CFG_ENABLE_A        = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ENABLE_B        = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SEND_EMPTY_IE_A = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SEND_EMPTY_IE_B = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_RECV_NE_IE_A    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_RECV_NE_IE_B    = 3'd5;

    localparam int IRQ_SEND_EMPTY = 0;
    localparam int IRQ_RECV_NE    = 1;

endpackage

/* src/dmf_ram.sv */
// Generic RAM with one write port and two registered read ports.
module dmf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr_a,
    output logic [WIDTH-1:0]  rd_data_a,
    input  logic [ADDR_W-1:0] rd_addr_b,
    output logic [WIDTH-1:0]  rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

/* src/dual_mailbox_fifo_core.sv */
// Top level of the dual mailbox FIFO core: two send FIFOs, status and interrupt pulses.
//
// Each side owns a send FIFO of FIFO_DEPTH words that is the other side's receive FIFO;
// both FIFOs share one RAM. A command beat is taken into an input register and fully
// processed from there into the result register, so the core accepts one beat per
// clock while the output side does not stall, and every command beat yields exactly
// one result beat. The RAM is read ahead at each FIFO's upcoming head pointer, with a
// bypass for a word written in that same cycle, so a receive never waits on the RAM.
// Configuration writes take effect at once and should only be made while no beats
// are in flight.
module dual_mailbox_fifo_core
    import dmf_pkg::*;
#(
    parameter int FIFO_DEPTH = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [DATA_W-1:0]      s_tdata,    // data_word
    input  logic [S_TUSER_W-1:0]   s_tuser,    // command[1:0], side[2]
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [M_TDATA_W-1:0]   m_tdata,    // read_data, status_a, status_b, irq_a, irq_b
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int PTR_W     = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W     = $clog2(FIFO_DEPTH + 1);
    localparam int ADDR_W    = PTR_W + 1;
    localparam int RAM_DEPTH = 2 << PTR_W;
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FIFO_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);

    logic                in_valid_reg;
    cmd_t                in_cmd_reg;
    logic                in_side_reg;
    logic [DATA_W-1:0]   in_word_reg;

    logic                out_valid_reg;
    logic [M_TDATA_W-1:0] out_data_reg;
    logic [M_TDATA_W-1:0] out_data_next;

    logic [PTR_W-1:0]    head_reg  [2];
    logic [PTR_W-1:0]    head_next [2];
    logic [PTR_W-1:0]    tail_reg  [2];
    logic [PTR_W-1:0]    tail_next [2];
    logic [CNT_W-1:0]    count_reg  [2];
    logic [CNT_W-1:0]    count_next [2];
    logic [DATA_W-1:0]   latch_reg  [2];
    logic [DATA_W-1:0]   latch_next [2];
    logic [1:0]          error_reg;
    logic [1:0]          error_next;

    logic [1:0]          enable_reg;
    logic [1:0]          send_empty_ie_reg;
    logic [1:0]          recv_ne_ie_reg;

    logic [1:0]          bypass_valid_reg;
    logic [DATA_W-1:0]   bypass_data_reg;

    logic                advance;
    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    logic [ADDR_W-1:0]   rd_addr [2];
    logic [DATA_W-1:0]   rd_data [2];
    logic [DATA_W-1:0]   front   [2];
    logic [IRQ_W-1:0]    irq     [2];
    logic                own;
    logic                other;

    function automatic logic [STATUS_W-1:0] status_word(
        input logic [CNT_W-1:0] own_cnt,
        input logic [CNT_W-1:0] other_cnt,
        input logic             err
    );
        status_word = {err, other_cnt == CNT_FULL, other_cnt == '0,
                       own_cnt == CNT_FULL, own_cnt == '0};
    endfunction

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_LAST) ? '0 : p + PTR_W'(1);
    endfunction

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign own   = in_side_reg;
    assign other = ~in_side_reg;

    assign front[0] = bypass_valid_reg[0] ? bypass_data_reg : rd_data[0];
    assign front[1] = bypass_valid_reg[1] ? bypass_data_reg : rd_data[1];

    assign rd_addr[0] = {1'b0, head_next[0]};
    assign rd_addr[1] = {1'b1, head_next[1]};

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        latch_next = latch_reg;
        error_next = error_reg;
        irq[0]     = '0;
        irq[1]     = '0;
        wr_en      = 1'b0;
        wr_addr    = {own, tail_reg[own]};
        if (advance)
        begin
            unique case (in_cmd_reg)
                CMD_SEND:
                begin
                    if (enable_reg[own])
                    begin
                        if (count_reg[own] != CNT_FULL)
                        begin
                            wr_en           = 1'b1;
                            tail_next[own]  = ptr_inc(tail_reg[own]);
                            count_next[own] = count_reg[own] + CNT_W'(1);
                            if (count_reg[own] == '0 && recv_ne_ie_reg[other])
                            begin
                                irq[other][IRQ_RECV_NE] = 1'b1;
                            end
                        end
                        else
                        begin
                            error_next[own] = 1'b1;
                        end
                    end
                end
                CMD_RECV:
                begin
                    if (count_reg[other] != '0)
                    begin
                        latch_next[own] = front[other];
                        if (enable_reg[own])
                        begin
                            head_next[other]  = ptr_inc(head_reg[other]);
                            count_next[other] = count_reg[other] - CNT_W'(1);
                            if (count_reg[other] == CNT_W'(1) && send_empty_ie_reg[other])
                            begin
                                irq[other][IRQ_SEND_EMPTY] = 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        error_next[own] = 1'b1;
                    end
                end
                CMD_CLEAR:
                begin
                    if (count_reg[own] != '0)
                    begin
                        count_next[own] = '0;
                        head_next[own]  = '0;
                        tail_next[own]  = '0;
                        latch_next[own] = '0;
                        if (send_empty_ie_reg[own])
                        begin
                            irq[own][IRQ_SEND_EMPTY] = 1'b1;
                        end
                    end
                end
                CMD_NOP:
                begin
                end
            endcase
        end
        out_data_next = M_TDATA_W'({irq[1], irq[0],
                         status_word(count_next[1], count_next[0], error_next[1]),
                         status_word(count_next[0], count_next[1], error_next[0]),
                         latch_next[own]});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            head_reg[0]       <= '0;
            head_reg[1]       <= '0;
            tail_reg[0]       <= '0;
            tail_reg[1]       <= '0;
            count_reg[0]      <= '0;
            count_reg[1]      <= '0;
            latch_reg[0]      <= '0;
            latch_reg[1]      <= '0;
            error_reg         <= '0;
            enable_reg        <= '0;
            send_empty_ie_reg <= '0;
            recv_ne_ie_reg    <= '0;
            bypass_valid_reg  <= '0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            count_reg  <= count_next;
            latch_reg  <= latch_next;
            error_reg  <= error_next;
            bypass_valid_reg[0] <= wr_en && (wr_addr == rd_addr[0]);
            bypass_valid_reg[1] <= wr_en && (wr_addr == rd_addr[1]);
            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_ENABLE_A:        enable_reg[0]        <= cfg_data[0];
                    CFG_ENABLE_B:        enable_reg[1]        <= cfg_data[0];
                    CFG_SEND_EMPTY_IE_A: send_empty_ie_reg[0] <= cfg_data[0];
                    CFG_SEND_EMPTY_IE_B: send_empty_ie_reg[1] <= cfg_data[0];
                    CFG_RECV_NE_IE_A:    recv_ne_ie_reg[0]    <= cfg_data[0];
                    CFG_RECV_NE_IE_B:    recv_ne_ie_reg[1]    <= cfg_data[0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_cmd_reg  <= cmd_t'(s_tuser[CMD_W-1:0]);
            in_side_reg <= s_tuser[CMD_W];
            in_word_reg <= s_tdata;
        end
        if (advance)
        begin
            out_data_reg <= out_data_next;
        end
        bypass_data_reg <= in_word_reg;
    end

    dmf_ram #(
        .WIDTH (DATA_W),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (in_word_reg),
        .rd_addr_a (rd_addr[0]),
        .rd_data_a (rd_data[0]),
        .rd_addr_b (rd_addr[1]),
        .rd_data_b (rd_data[1])
    );

endmodule
